// File: rtl/vslp_pkg.sv
// Shared types and constants for the variable-step low-pass filter.
package vslp_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned TcW      = 24;
  localparam int unsigned GapW     = 20;
  localparam int unsigned StepW    = 16;
  localparam int unsigned DenW     = TcW + 1;
  localparam int unsigned NumW     = 57;
  localparam int unsigned MacSteps = TcW;
  localparam int unsigned DivSteps = NumW;
  localparam int unsigned MacCntW  = $clog2(MacSteps);
  localparam int unsigned DivCntW  = $clog2(DivSteps);
  localparam int unsigned AddrW    = 4;

  localparam logic [TcW-1:0]   TcReset   = '0;
  localparam logic [GapW-1:0]  GapReset  = GapW'(500000);
  localparam logic [StepW-1:0] StepReset = StepW'(100);

  typedef enum logic [1:0] {
    RegTimeConst = 2'd0,
    RegGapLimit  = 2'd1,
    RegMinStep   = 2'd2,
    RegNone      = 2'd3
  } vslp_reg_e;

  typedef enum logic [2:0] {
    StIdle,
    StSetup,
    StMul,
    StDiv,
    StFix
  } vslp_state_e;

endpackage

// File: rtl/variable_step_lowpass_filter.sv
// Top level of the variable-step first-order low-pass filter with APB register port.
// Each item carries a signed Q16.16 sample and a wrapping 32-bit microsecond timestamp and
// yields one result: (Tf*y_prev + dt*x)/(Tf+dt) truncated toward zero, or the sample itself
// with restarted set when the filter is not yet primed or dt exceeds the gap limit. A filtered
// item passes through the setup state, 24 bit-serial multiply-accumulate steps, a handoff
// from the multiply-accumulate done flag to the divider start, 57 restoring-divider steps
// (one quotient bit per cycle), the divider done flag and the close-out state, which loads
// the result into the output register. A restart item goes from the setup state straight
// to the close-out state. The next item is taken in the cycle after the result is loaded;
// a result still waiting in the output register holds back only loading the next result.
// Registers: time_constant_us at 0x0, gap_limit_us at 0x4, min_step_us at 0x8.
module variable_step_lowpass_filter import vslp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [AddrW-1:0]        paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [DataW-1:0] sample_i,
  input  logic [DataW-1:0]        timestamp_us_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [DataW-1:0] filtered_o,
  output logic                    restarted_o
);

  vslp_state_e state_q, state_d;

  logic [TcW-1:0]   tc_q;
  logic [GapW-1:0]  gap_q;
  logic [StepW-1:0] step_q;
  vslp_reg_e        reg_sel;
  logic             cfg_wr;

  logic signed [DataW-1:0] x_q;
  logic [DataW-1:0]        now_q;
  logic signed [DataW-1:0] last_out_q;
  logic [DataW-1:0]        last_time_q;
  logic                    primed_q;
  logic [GapW-1:0]         dt_q;
  logic                    restart_q;
  logic                    out_valid_q;
  logic signed [DataW-1:0] filtered_q;
  logic                    restarted_q;

  logic [DataW-1:0]        dt_raw;
  logic [DataW-1:0]        dt_eff;
  logic                    restart_w;
  logic                    in_fire;
  logic                    fix_fire;
  logic                    mac_start;
  logic                    div_start;
  logic                    mac_done;
  logic                    div_done;
  logic signed [NumW-1:0]  num;
  logic [DenW-1:0]         den;
  logic [DataW-1:0]        quot;

  // Configuration port
  assign reg_sel = vslp_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    unique case (reg_sel)
      RegTimeConst: prdata = 32'(tc_q);
      RegGapLimit:  prdata = 32'(gap_q);
      RegMinStep:   prdata = 32'(step_q);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q   <= TcReset;
      gap_q  <= GapReset;
      step_q <= StepReset;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        RegTimeConst: tc_q   <= pwdata[TcW-1:0];
        RegGapLimit:  gap_q  <= pwdata[GapW-1:0];
        RegMinStep:   step_q <= pwdata[StepW-1:0];
        default:      ;
      endcase
    end
  end

  // Step size and restart decision
  always_comb begin
    dt_raw = now_q - last_time_q;
    if (dt_raw != '0) begin
      dt_eff = dt_raw;
    end else if (step_q == '0) begin
      dt_eff = DataW'(1);
    end else begin
      dt_eff = DataW'(step_q);
    end
    restart_w = !primed_q || (dt_eff > DataW'(gap_q));
  end

  assign in_fire  = in_valid_i && in_ready_o;
  assign den      = DenW'(tc_q) + DenW'(dt_q);

  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_fire) state_d = StSetup;
      StSetup: state_d = restart_w ? StFix : StMul;
      StMul:   if (mac_done) state_d = StDiv;
      StDiv:   if (div_done) state_d = StFix;
      StFix:   if (!out_valid_q || out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_ready_o = 1'b0;
    mac_start  = 1'b0;
    div_start  = 1'b0;
    fix_fire   = 1'b0;
    unique case (state_q)
      StIdle:  in_ready_o = 1'b1;
      StSetup: mac_start  = !restart_w;
      StMul:   div_start  = mac_done;
      StDiv:   ;
      StFix:   fix_fire   = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      primed_q    <= 1'b0;
      last_out_q  <= '0;
      last_time_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fix_fire) begin
        primed_q    <= 1'b1;
        last_out_q  <= restart_q ? x_q : quot;
        last_time_q <= now_q;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q   <= sample_i;
      now_q <= timestamp_us_i;
    end
    if (state_q == StSetup) begin
      dt_q      <= dt_eff[GapW-1:0];
      restart_q <= restart_w;
    end
    if (fix_fire) begin
      filtered_q  <= restart_q ? x_q : quot;
      restarted_q <= restart_q;
    end
  end

  vslp_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mac_start),
    .tf_i    (tc_q),
    .dt_i    (dt_eff[GapW-1:0]),
    .yp_i    (last_out_q),
    .x_i     (x_q),
    .done_o  (mac_done),
    .num_o   (num)
  );

  vslp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filtered_q;
  assign restarted_o = restarted_q;

`ifndef SYNTHESIS
  a_mac_done_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> state_q == StMul)
    else $error("multiply-accumulate finished outside its phase");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == StDiv)
    else $error("divider finished outside its phase");

  a_state_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fix_fire |=> primed_q && out_valid_q && last_time_q == $past(now_q))
    else $error("filter state not updated with the result");

  a_restart_unprimed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSetup) && !primed_q |-> restart_w && !mac_start)
    else $error("unprimed item entered the arithmetic path");
`endif

endmodule

// File: rtl/vslp_mac.sv
// Bit-serial multiply-accumulate: tf*yp + dt*x, one multiplier bit per cycle, MSB first.
module vslp_mac import vslp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [TcW-1:0]         tf_i,
  input  logic [GapW-1:0]        dt_i,
  input  logic signed [DataW-1:0] yp_i,
  input  logic signed [DataW-1:0] x_i,
  output logic                   done_o,
  output logic signed [NumW-1:0] num_o
);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [MacCntW-1:0]     cnt_q, cnt_d;
  logic [TcW-1:0]         tf_sh_q, tf_sh_d;
  logic [TcW-1:0]         dt_sh_q, dt_sh_d;
  logic signed [NumW-1:0] acc_q, acc_d;
  logic signed [NumW-1:0] yp_term, x_term;

  always_comb begin
    yp_term = tf_sh_q[TcW-1] ? NumW'(yp_i) : '0;
    x_term  = dt_sh_q[TcW-1] ? NumW'(x_i) : '0;
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    tf_sh_d = tf_sh_q;
    dt_sh_d = dt_sh_q;
    acc_d   = acc_q;
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = '0;
      tf_sh_d = tf_i;
      dt_sh_d = TcW'(dt_i);
      acc_d   = '0;
    end else if (busy_q) begin
      acc_d   = (acc_q <<< 1) + yp_term + x_term;
      tf_sh_d = {tf_sh_q[TcW-2:0], 1'b0};
      dt_sh_d = {dt_sh_q[TcW-2:0], 1'b0};
      cnt_d   = cnt_q + 1'b1;
      if (cnt_q == MacCntW'(MacSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tf_sh_q <= tf_sh_d;
    dt_sh_q <= dt_sh_d;
    acc_q   <= acc_d;
  end

  assign done_o = done_q;
  assign num_o  = acc_q;

endmodule

// File: rtl/vslp_div.sv
// Restoring divider: signed numerator by unsigned denominator, one quotient bit per cycle.
module vslp_div import vslp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NumW-1:0]  num_i,
  input  logic [DenW-1:0]         den_i,
  output logic                    done_o,
  output logic [DataW-1:0]        quot_o
);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic                neg_q, neg_d;
  logic [DenW-1:0]     den_q, den_d;
  logic [DenW-1:0]     rem_q, rem_d;
  logic [NumW-1:0]     quo_q, quo_d;
  logic [DenW:0]       rem_sh;
  logic [DenW:0]       diff;
  logic                borrow;
  logic [NumW-1:0]     mag;

  always_comb begin
    mag    = num_i[NumW-1] ? NumW'(-num_i) : NumW'(num_i);
    rem_sh = {rem_q, quo_q[NumW-1]};
    diff   = rem_sh - {1'b0, den_q};
    borrow = rem_sh < {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      neg_d  = num_i[NumW-1];
      den_d  = den_i;
      rem_d  = '0;
      quo_d  = mag;
    end else if (busy_q) begin
      rem_d = borrow ? rem_sh[DenW-1:0] : diff[DenW-1:0];
      quo_d = {quo_q[NumW-2:0], ~borrow};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  // The quotient magnitude always fits the result word; apply the sign.
  assign quot_o = neg_q ? (~quo_q[DataW-1:0] + 1'b1) : quo_q[DataW-1:0];
  assign done_o = done_q;

endmodule
